// File: hw/rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the contiguous bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam int UNITS_DEFAULT = 128;

  localparam int SIZE_W = 8;
  localparam int POS_W  = 7;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;
  localparam logic [1:0] POLICY_RESET = POLICY_BEST;

  localparam int REG_FIT_POLICY = 0;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  start_unit;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfa_core.sv
// ----------------------------------------------------------------------------
// bfa_core
// Occupancy map memory with the sequencer that clears, scans and marks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_core #(
  parameter int UNITS = bfa_pkg::UNITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  input  wire bfa_pkg::req_t req,
  input  wire logic [1:0]    policy,
  input  wire logic          res_ready,
  output logic               idle,
  output logic               res_valid,
  output bfa_pkg::res_t      res
);

  localparam int IW = $clog2(UNITS);
  localparam int AW = $clog2(UNITS + 1);
  localparam int LW = AW;
  localparam int WW = ((AW > bfa_pkg::SIZE_W) ? AW : bfa_pkg::SIZE_W) + 1;

  localparam logic [AW-1:0] UNITS_A = AW'(UNITS);
  localparam logic [WW-1:0] UNITS_W = WW'(UNITS);
  localparam logic [IW-1:0] LAST_I  = IW'(UNITS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MARK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                      mem_r [UNITS];
  logic                      rd_bit_r;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic [AW-1:0]             lim_r, lim_nxt;
  logic                      mark_bit_r, mark_bit_nxt;
  logic [bfa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic                      in_run_r, in_run_nxt;
  logic [IW-1:0]             cur_start_r, cur_start_nxt;
  logic [LW-1:0]             cur_len_r, cur_len_nxt;
  logic                      found_r, found_nxt;
  logic [IW-1:0]             best_start_r, best_start_nxt;
  logic [LW-1:0]             best_len_r, best_len_nxt;
  bfa_pkg::res_t             res_r, res_nxt;

  logic          rd_en;
  logic          wr_en;
  logic          wr_bit;
  logic [IW-1:0] run_start;
  logic [LW-1:0] run_len;
  logic          ev_en;
  logic [IW-1:0] ev_start;
  logic [LW-1:0] ev_len;
  logic          ev_fits;
  logic          ev_take;
  logic [WW-1:0] free_end;
  logic [WW-1:0] free_lim;
  logic [WW-1:0] alloc_end;

  always_comb begin
    run_start = in_run_r ? cur_start_r : rd_idx_r;
    run_len   = in_run_r ? cur_len_r + LW'(1) : LW'(1);
    if (!rd_bit_r && rd_idx_r == LAST_I) begin
      ev_en    = rd_vld_r;
      ev_start = run_start;
      ev_len   = run_len;
    end else begin
      ev_en    = rd_vld_r && rd_bit_r && in_run_r;
      ev_start = cur_start_r;
      ev_len   = cur_len_r;
    end
    ev_fits = WW'(ev_len) >= WW'(size_r);
    ev_take = ev_en && ev_fits &&
              (!found_r ||
               (policy == bfa_pkg::POLICY_BEST  && ev_len < best_len_r) ||
               (policy == bfa_pkg::POLICY_WORST && ev_len > best_len_r));
  end

  always_comb begin
    free_end  = WW'(req.start_unit) + WW'(req.size);
    free_lim  = (free_end < UNITS_W) ? free_end : UNITS_W;
    alloc_end = WW'(best_start_nxt) + WW'(size_r);
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    mark_bit_nxt   = mark_bit_r;
    size_nxt       = size_r;
    in_run_nxt     = in_run_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    found_nxt      = found_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    res_nxt        = res_r;
    rd_en          = 1'b0;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    wr_en          = 1'b0;
    wr_bit         = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r[IW-1:0] == LAST_I) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          size_nxt = req.size;
          if (req.kind == bfa_pkg::KIND_FREE) begin
            res_nxt.granted  = 1'b1;
            res_nxt.position = req.start_unit;
            if (WW'(req.start_unit) < UNITS_W) begin
              ptr_nxt      = AW'(req.start_unit);
              lim_nxt      = AW'(free_lim);
              mark_bit_nxt = 1'b0;
              state_nxt    = ST_MARK;
            end else begin
              state_nxt = ST_DONE;
            end
          end else if (req.size == '0) begin
            res_nxt.granted  = 1'b0;
            res_nxt.position = '0;
            state_nxt        = ST_DONE;
          end else begin
            ptr_nxt    = '0;
            in_run_nxt = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ptr_r < UNITS_A) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IW-1:0];
          ptr_nxt    = ptr_r + AW'(1);
        end
        if (rd_vld_r) begin
          in_run_nxt = !rd_bit_r;
          if (!rd_bit_r) begin
            cur_start_nxt = run_start;
            cur_len_nxt   = run_len;
          end
        end
        if (ev_take) begin
          found_nxt      = 1'b1;
          best_start_nxt = ev_start;
          best_len_nxt   = ev_len;
        end
        if (rd_vld_r && rd_idx_r == LAST_I) begin
          if (found_nxt) begin
            res_nxt.granted  = 1'b1;
            res_nxt.position = bfa_pkg::POS_W'(best_start_nxt);
            ptr_nxt          = AW'(best_start_nxt);
            lim_nxt          = AW'(alloc_end);
            mark_bit_nxt     = 1'b1;
            state_nxt        = ST_MARK;
          end else begin
            res_nxt.granted  = 1'b0;
            res_nxt.position = '0;
            state_nxt        = ST_DONE;
          end
        end
      end
      ST_MARK: begin
        if (ptr_r < lim_r) begin
          wr_en   = 1'b1;
          wr_bit  = mark_bit_r;
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        ptr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[ptr_r[IW-1:0]] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit_r <= mem_r[ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      in_run_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
      in_run_r <= in_run_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    lim_r        <= lim_nxt;
    mark_bit_r   <= mark_bit_nxt;
    size_r       <= size_nxt;
    cur_start_r  <= cur_start_nxt;
    cur_len_r    <= cur_len_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    res_r        <= res_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_fit_allocator
// Contiguous first, best or worst fit allocator over a one-bit occupancy map.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid, in_stall   in_kind, in_size, in_start_unit
//   out_     output     out_valid, out_stall out_granted, out_position
//   cfg      input      psel, penable, ...   fit_policy at byte address 0
//
// A granted allocate scans the whole map and then marks its size units; a failed
// one only scans the map, and a zero-size one returns its word without a scan.
// A free clears size units, clipped at the map end, then returns its word.
// The occupancy memory is single-port and is read or written one unit per cycle.
// After reset a clearing pass over all UNITS units runs before any word is taken.
// A result word waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_fit_allocator #(
  parameter int UNITS = bfa_pkg::UNITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_kind,
  input  wire logic [bfa_pkg::SIZE_W-1:0]  in_size,
  input  wire logic [bfa_pkg::POS_W-1:0]   in_start_unit,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_granted,
  output logic [bfa_pkg::POS_W-1:0]        out_position,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic          policy_sel;
  logic [1:0]    policy_r;
  logic          core_idle;
  logic          res_valid;
  logic          res_ready;
  bfa_pkg::req_t req;
  bfa_pkg::res_t res;
  logic          out_valid_r;
  bfa_pkg::res_t out_r;

  assign pready     = 1'b1;
  assign policy_sel = (32'(paddr[2]) == bfa_pkg::REG_FIT_POLICY);
  assign prdata     = policy_sel ? {30'd0, policy_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= bfa_pkg::POLICY_RESET;
    end else if (psel && penable && pwrite && policy_sel) begin
      policy_r <= pwdata[1:0];
    end
  end

  assign req.kind       = in_kind;
  assign req.size       = in_size;
  assign req.start_unit = in_start_unit;
  assign in_stall       = !core_idle;
  assign res_ready      = !out_valid_r || !out_stall;

  bfa_core #(
    .UNITS(UNITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_valid && core_idle),
    .req      (req),
    .policy   (policy_r),
    .res_ready(res_ready),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_granted  = out_r.granted;
  assign out_position = out_r.position;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("core still idle after taking a word");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && out_stall |=> res_valid)
    else $error("result dropped while the output register was full");

  a_fail_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_position == '0)
    else $error("failed allocation reports a nonzero position");
`endif

endmodule

`default_nettype wire

// File: tb/bitmap_fit_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_fit_allocator_checker
// Watches the request, result and register ports of the allocator. It keeps
// its own occupancy map and placement rule and predicts the grant and position
// of every accepted request word. Each accepted result word is then compared
// in order against that prediction.
// ----------------------------------------------------------------------------

module bitmap_fit_allocator_checker #(
  parameter int UNITS = bfa_pkg::UNITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_kind,
  input  logic [bfa_pkg::SIZE_W-1:0] in_size,
  input  logic [bfa_pkg::POS_W-1:0]  in_start_unit,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_granted,
  input  logic [bfa_pkg::POS_W-1:0]  out_position,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output int                         mismatches,
  output int                         outstanding
);
  import bfa_pkg::*;

  logic [UNITS-1:0] occupied;
  logic [1:0]       fit_rule;
  res_t             pending_grants[$];
  req_t             taken_req;
  res_t             want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic res_t place_or_release(input req_t r);
    int   u;
    int   run_start;
    int   run_len;
    int   pick_start;
    int   pick_len;
    int   last;
    bit   found;
    bit   stop;
    res_t res;
    res = '0;
    if (r.kind == KIND_FREE) begin
      last = int'(r.start_unit) + int'(r.size);
      for (u = int'(r.start_unit); u < last && u < UNITS; u++) begin
        occupied[u] = 1'b0;
      end
      res.granted  = 1'b1;
      res.position = r.start_unit;
      return res;
    end
    if (r.size == '0) begin
      return res;
    end
    u          = 0;
    found      = 1'b0;
    stop       = 1'b0;
    pick_start = 0;
    pick_len   = 0;
    while (u < UNITS && !stop) begin
      if (occupied[u]) begin
        u++;
      end else begin
        run_start = u;
        while (u < UNITS && !occupied[u]) u++;
        run_len = u - run_start;
        if (run_len >= int'(r.size)) begin
          if (!found) begin
            found      = 1'b1;
            pick_start = run_start;
            pick_len   = run_len;
            if (fit_rule != POLICY_BEST && fit_rule != POLICY_WORST) begin
              stop = 1'b1;
            end
          end else if (fit_rule == POLICY_BEST && run_len < pick_len) begin
            pick_start = run_start;
            pick_len   = run_len;
          end else if (fit_rule == POLICY_WORST && run_len > pick_len) begin
            pick_start = run_start;
            pick_len   = run_len;
          end
        end
      end
    end
    if (found) begin
      for (u = pick_start; u < pick_start + int'(r.size); u++) begin
        occupied[u] = 1'b1;
      end
      res.granted  = 1'b1;
      res.position = POS_W'(pick_start);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      occupied = '0;
      fit_rule = POLICY_RESET;
      pending_grants.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_FIT_POLICY)) begin
        fit_rule = pwdata[1:0];
      end
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual granted=%0d position=%0d",
                   $time, out_granted, out_position);
          mismatches++;
        end else begin
          want = pending_grants.pop_front();
          if (out_granted !== want.granted) begin
            $display("%0t: granted mismatch: expected %0d, actual %0d",
                     $time, want.granted, out_granted);
            mismatches++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, want.position, out_position);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        taken_req.kind       = in_kind;
        taken_req.size       = in_size;
        taken_req.start_unit = in_start_unit;
        pending_grants.push_back(place_or_release(taken_req));
      end
    end
    outstanding = pending_grants.size();
  end

endmodule

// File: tb/bitmap_fit_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_fit_allocator_tb
// Drives the allocator with a short directed sequence of corner cases and then
// with phases of random allocate and free words, one placement rule per phase.
// The rule is rewritten only when the block is idle. Both channels idle and
// stall at random. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------

module bitmap_fit_allocator_tb;
  import bfa_pkg::*;

  localparam int         UNITS         = UNITS_DEFAULT;
  localparam logic [1:0] POLICY_UNUSED = 2'd3;
  localparam int         PHASES        = 6;
  localparam int         PHASE_WORDS   = 150;
  localparam logic [11:0] PHASE_RULES  = {POLICY_WORST, POLICY_FIRST, POLICY_BEST,
                                          POLICY_UNUSED, POLICY_WORST, POLICY_FIRST};

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic              in_kind       = 1'b0;
  logic [SIZE_W-1:0] in_size       = '0;
  logic [POS_W-1:0]  in_start_unit = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              out_granted;
  logic [POS_W-1:0]  out_position;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [2:0]        paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                mismatches;
  int                outstanding;
  bit                tx_steady;
  bit                rx_steady;
  bit                rx_armed;
  int                rx_left;
  int                results_taken;
  int                results_seen;
  int                phase;
  int                n;
  logic              word_kind;
  logic [SIZE_W-1:0] word_size;
  logic [POS_W-1:0]  word_start;

  bitmap_fit_allocator #(.UNITS(UNITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_size      (in_size),
    .in_start_unit(in_start_unit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_granted  (out_granted),
    .out_position (out_position),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bitmap_fit_allocator_checker #(.UNITS(UNITS)) fit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_size      (in_size),
    .in_start_unit(in_start_unit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_granted  (out_granted),
    .out_position (out_position),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) results_taken++;
  end

  // The receiver holds off a result word for a drawn number of cycles unless in a steady spell.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        rx_armed     = 1'b0;
      end
      if (out_valid && !rx_armed) begin
        rx_armed = 1'b1;
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        rx_left = rx_steady ? 0 : $urandom_range(0, 9);
      end
      if (rx_left != 0) begin
        out_stall <= 1'b1;
        rx_left--;
      end else if (!out_valid && !rx_steady) begin
        out_stall <= 1'($urandom_range(0, 1));
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic k, input logic [SIZE_W-1:0] sz,
                           input logic [POS_W-1:0] su);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_size       <= sz;
    in_start_unit <= su;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (UNITS + 8) @(negedge clk);
  endtask

  task automatic write_fit_policy(input logic [1:0] rule);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_FIT_POLICY);
    pwdata  <= {30'd0, rule};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly small allocations against random frees, so the map fragments.
  task automatic next_random_word(output logic k, output logic [SIZE_W-1:0] sz,
                                  output logic [POS_W-1:0] su);
    int pick;
    k    = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_FREE;
    su   = POS_W'($urandom_range(0, UNITS - 1));
    pick = $urandom_range(0, 99);
    if (k == KIND_ALLOC) begin
      if (pick < 70)      sz = SIZE_W'($urandom_range(1, 16));
      else if (pick < 85) sz = SIZE_W'($urandom_range(17, 64));
      else if (pick < 93) sz = SIZE_W'($urandom_range(65, 128));
      else if (pick < 96) sz = '0;
      else                sz = SIZE_W'($urandom_range(129, 255));
    end else begin
      if (pick < 75)      sz = SIZE_W'($urandom_range(1, 16));
      else if (pick < 87) sz = SIZE_W'($urandom_range(17, 128));
      else if (pick < 91) sz = '0;
      else if (pick < 95) sz = SIZE_W'($urandom_range(129, 255));
      else begin
        su = '0;
        sz = SIZE_W'(UNITS);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(KIND_ALLOC, 8'd0,   7'd0);
    send_word(KIND_ALLOC, 8'd255, 7'd127);
    send_word(KIND_ALLOC, 8'd129, 7'd0);
    send_word(KIND_ALLOC, 8'd128, 7'd0);
    send_word(KIND_ALLOC, 8'd1,   7'd0);
    send_word(KIND_FREE,  8'd128, 7'd0);
    send_word(KIND_ALLOC, 8'd10,  7'd127);
    send_word(KIND_ALLOC, 8'd20,  7'd85);
    send_word(KIND_ALLOC, 8'd30,  7'd42);
    send_word(KIND_ALLOC, 8'd5,   7'd0);
    send_word(KIND_ALLOC, 8'd40,  7'd0);
    send_word(KIND_FREE,  8'd20,  7'd10);
    send_word(KIND_FREE,  8'd5,   7'd60);
    send_word(KIND_ALLOC, 8'd4,   7'd0);
    send_word(KIND_ALLOC, 8'd21,  7'd0);
    send_word(KIND_FREE,  8'd0,   7'd0);
    send_word(KIND_FREE,  8'd255, 7'd120);
    send_word(KIND_FREE,  8'd1,   7'd127);
    send_word(KIND_FREE,  8'd8,   7'd100);
    send_word(KIND_ALLOC, 8'd2,   7'd0);
    send_word(KIND_FREE,  8'd128, 7'd0);
    send_word(KIND_ALLOC, 8'd64,  7'd0);
    send_word(KIND_ALLOC, 8'd64,  7'd0);
    send_word(KIND_ALLOC, 8'd1,   7'd0);
    send_word(KIND_FREE,  8'd128, 7'd0);
    drain_requests();

    for (phase = 0; phase < PHASES; phase++) begin
      write_fit_policy(PHASE_RULES[2*phase +: 2]);
      for (n = 0; n < PHASE_WORDS; n++) begin
        next_random_word(word_kind, word_size, word_start);
        send_word(word_kind, word_size, word_start);
      end
      drain_requests();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_core.sv
hw/rtl/bitmap_fit_allocator.sv
tb/bitmap_fit_allocator_checker.sv
tb/bitmap_fit_allocator_tb.sv
